// ===== sv/spd_pkg.sv =====
// Shared types and constants for the slotted page directory.
// No dependencies; imported by the top level and its checker.
package spd_pkg;

    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int SLOT_BYTES_DEF   = 4;
    localparam int MAX_SLOTS_DEF    = 1024;

    localparam int REQ_W    = 2;
    localparam int LEN_W    = 13;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT      = 2'd0,
        REQ_INSERT    = 2'd1,
        REQ_TOMBSTONE = 2'd2,
        REQ_LOOKUP    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOROOM   = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

endpackage

// ===== sv/slotted_page_directory.sv =====
// Slotted page directory: request register, slot directory memory and result register.
// Depends on spd_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready with req_type, record_length and
//   slot_number. Each request yields exactly one result on out_valid/out_ready
//   carrying status, slot_index, record_offset, length_out and free_bytes.
//   The request and its directory read are registered together in the request
//   register, then the result register loads and presents the result on
//   out_valid.
//   Throughput: one request per cycle while out_ready takes the results, set
//   by the registered read of the slot directory memory; a read that hits the
//   entry being written in the same cycle takes the new data through a bypass.
//   Reset: the page is empty (no slots, free end at the page end); directory
//   entries are not cleared, since only entries below the slot count are read.
//   Init does the same without touching the memory.
//   Stall: while out_ready is low the result holds, one more request may sit
//   in the request register, and in_ready drops once both are occupied.
module slotted_page_directory
    import spd_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = SLOT_BYTES_DEF,
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [LEN_W-1:0]    record_length,
    input  logic [SLOT_W-1:0]   slot_number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_index,
    output logic [LEN_W-1:0]    record_offset,
    output logic [LEN_W-1:0]    length_out,
    output logic [LEN_W-1:0]    free_bytes
);

    localparam int AW    = $clog2(MAX_SLOTS);
    localparam int CNTW  = $clog2(MAX_SLOTS + 1);
    localparam int PW    = $clog2(PAGE_BYTES + 1);
    localparam int DLIM  = HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES;
    localparam int ALIM  = (DLIM > PAGE_BYTES) ? DLIM : PAGE_BYTES;
    localparam int CW0   = $clog2(ALIM + 1);
    localparam int CW    = (CW0 > LEN_W + 1) ? CW0 : LEN_W + 1;
    localparam int SCW   = (CNTW > SLOT_W) ? CNTW : SLOT_W;

    // slot directory
    logic [PW-1:0]    mem_off [MAX_SLOTS];
    logic [LEN_W-1:0] mem_len [MAX_SLOTS];

    // page state
    logic [CNTW-1:0]  slot_count_reg, slot_count_next;
    logic [PW-1:0]    free_end_reg, free_end_next;
    logic [CW-1:0]    dir_end_reg, dir_end_next;

    // request register and read data
    logic             s1_valid_reg;
    req_t             s1_req_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [PW-1:0]    rd_off_reg;
    logic [LEN_W-1:0] rd_len_reg;

    // result register
    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   slot_index_reg, slot_index_next;
    logic [LEN_W-1:0]    record_offset_reg, record_offset_next;
    logic [LEN_W-1:0]    length_out_reg, length_out_next;
    logic [LEN_W-1:0]    free_bytes_reg, free_bytes_next;

    // directory writes
    logic             wr_off_en, wr_len_en;
    logic [AW-1:0]    wr_addr;
    logic [PW-1:0]    wr_off_data;
    logic [LEN_W-1:0] wr_len_data;

    logic             advance, accept;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    fe_ext, len_ext, new_off, fe_n_ext;
    logic             fits, slot_in_range;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign rd_addr  = AW'(slot_number);

    assign fe_ext        = CW'(free_end_reg);
    assign len_ext       = CW'(s1_len_reg);
    assign new_off       = fe_ext - len_ext;
    assign slot_in_range = SCW'(s1_slot_reg) < SCW'(slot_count_reg);
    assign fits          = (slot_count_reg < CNTW'(MAX_SLOTS)) && (fe_ext >= len_ext)
                           && (new_off >= dir_end_reg + CW'(SLOT_BYTES));

    always_comb
    begin
        slot_count_next    = slot_count_reg;
        free_end_next      = free_end_reg;
        dir_end_next       = dir_end_reg;
        status_next        = ST_OK;
        slot_index_next    = '0;
        record_offset_next = '0;
        length_out_next    = '0;
        wr_off_en          = 1'b0;
        wr_len_en          = 1'b0;
        wr_addr            = AW'(s1_slot_reg);
        wr_off_data        = PW'(new_off);
        wr_len_data        = '0;
        unique case (s1_req_reg)
            REQ_INIT:
            begin
                slot_count_next = '0;
                free_end_next   = PW'(PAGE_BYTES);
                dir_end_next    = CW'(HEADER_BYTES);
            end
            REQ_INSERT:
            begin
                if (fits)
                begin
                    wr_off_en          = 1'b1;
                    wr_len_en          = 1'b1;
                    wr_addr            = AW'(slot_count_reg);
                    wr_len_data        = s1_len_reg;
                    slot_index_next    = SLOT_W'(slot_count_reg);
                    record_offset_next = LEN_W'(new_off);
                    slot_count_next    = slot_count_reg + CNTW'(1);
                    free_end_next      = PW'(new_off);
                    dir_end_next       = dir_end_reg + CW'(SLOT_BYTES);
                end
                else
                begin
                    status_next = ST_NOROOM;
                end
            end
            REQ_TOMBSTONE:
            begin
                if (slot_in_range)
                begin
                    wr_len_en = 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            REQ_LOOKUP:
            begin
                if (slot_in_range && (rd_len_reg != '0))
                begin
                    record_offset_next = LEN_W'(rd_off_reg);
                    length_out_next    = rd_len_reg;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign fe_n_ext        = CW'(free_end_next);
    assign free_bytes_next = (fe_n_ext > dir_end_next) ? LEN_W'(fe_n_ext - dir_end_next)
                                                       : '0;

    // Directory memory: write on advance, registered read on accept with bypass.
    always_ff @(posedge clk)
    begin
        if (advance && wr_off_en)
        begin
            mem_off[wr_addr] <= wr_off_data;
        end
        if (advance && wr_len_en)
        begin
            mem_len[wr_addr] <= wr_len_data;
        end
        if (accept)
        begin
            rd_off_reg <= (advance && wr_off_en && (wr_addr == rd_addr)) ? wr_off_data
                                                                          : mem_off[rd_addr];
            rd_len_reg <= (advance && wr_len_en && (wr_addr == rd_addr)) ? wr_len_data
                                                                          : mem_len[rd_addr];
            s1_req_reg  <= req_t'(req_type);
            s1_len_reg  <= record_length;
            s1_slot_reg <= slot_number;
        end
        if (advance)
        begin
            status_reg        <= status_next;
            slot_index_reg    <= slot_index_next;
            record_offset_reg <= record_offset_next;
            length_out_reg    <= length_out_next;
            free_bytes_reg    <= free_bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_count_reg <= '0;
            free_end_reg   <= PW'(PAGE_BYTES);
            dir_end_reg    <= CW'(HEADER_BYTES);
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                slot_count_reg <= slot_count_next;
                free_end_reg   <= free_end_next;
                dir_end_reg    <= dir_end_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot_index    = slot_index_reg;
    assign record_offset = record_offset_reg;
    assign length_out    = length_out_reg;
    assign free_bytes    = free_bytes_reg;

endmodule

// ===== sv/spd_checker.sv =====
// Port-level checks for the slotted page directory, bound to the top level.
// Depends on spd_pkg and slotted_page_directory.
module spd_port_checks
    import spd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [SLOT_W-1:0]   slot_index,
    input logic [LEN_W-1:0]    record_offset,
    input logic [LEN_W-1:0]    length_out,
    input logic [LEN_W-1:0]    free_bytes
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
            && $stable(record_offset) && $stable(length_out) && $stable(free_bytes))
        else $error("result changed while stalled");

    a_noroom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOROOM) |->
            (slot_index == '0) && (record_offset == '0) && (length_out == '0))
        else $error("failed insert carries slot data");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOTFOUND) |->
            (slot_index == '0) && (record_offset == '0) && (length_out == '0))
        else $error("missing slot carries slot data");

    // only a successful lookup reports a length, and lookups assign no slot
    a_length_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (length_out != '0) |-> (status == ST_OK) && (slot_index == '0))
        else $error("length reported outside a successful lookup");

endmodule

bind slotted_page_directory spd_port_checks u_spd_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_index    (slot_index),
    .record_offset (record_offset),
    .length_out    (length_out),
    .free_bytes    (free_bytes)
);

// ===== tb/spd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the slotted page directory: tracks the page layout from every
// request transaction and compares each result transaction field by field.
// Depends on spd_pkg for the request and status codes and the field widths.
module spd_checker
    import spd_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int SLOT_BYTES   = SLOT_BYTES_DEF,
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [LEN_W-1:0]    record_length,
    input  logic [SLOT_W-1:0]   slot_number,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic [LEN_W-1:0]    record_offset,
    input  logic [LEN_W-1:0]    length_out,
    input  logic [LEN_W-1:0]    free_bytes,
    output int                  mismatches,
    output int                  pending
);

    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot_index;
        logic [LEN_W-1:0]  record_offset;
        logic [LEN_W-1:0]  length_out;
        logic [LEN_W-1:0]  free_bytes;
    } page_result_t;

    page_result_t     awaited_results[$];
    int               used_slots   = 0;
    int               page_free_end = PAGE_BYTES;
    int               fail_tally   = 0;
    int               outstanding  = 0;
    logic [LEN_W-1:0] entry_offset [MAX_SLOTS];
    logic [LEN_W-1:0] entry_length [MAX_SLOTS];

    assign mismatches = fail_tally;
    assign pending    = outstanding;

    function automatic int directory_end(int entries);
        return HEADER_BYTES + entries * SLOT_BYTES;
    endfunction

    // Apply one request to the tracked page and return the result it must produce.
    function automatic page_result_t apply_page_request(req_t req, int len, int slot);
        page_result_t r;
        int           new_off;
        r.status        = ST_OK;
        r.slot_index    = '0;
        r.record_offset = '0;
        r.length_out    = '0;
        r.free_bytes    = '0;
        case (req)
            REQ_INIT:
            begin
                used_slots    = 0;
                page_free_end = PAGE_BYTES;
            end
            REQ_INSERT:
            begin
                // record plus one more directory entry must fit below the free end
                new_off = page_free_end - len;
                if (used_slots >= MAX_SLOTS || new_off < directory_end(used_slots + 1))
                begin
                    r.status = ST_NOROOM;
                end
                else
                begin
                    entry_offset[used_slots] = LEN_W'(new_off);
                    entry_length[used_slots] = LEN_W'(len);
                    r.slot_index    = SLOT_W'(used_slots);
                    r.record_offset = LEN_W'(new_off);
                    used_slots++;
                    page_free_end = new_off;
                end
            end
            REQ_TOMBSTONE:
            begin
                if (slot >= used_slots)
                    r.status = ST_NOTFOUND;
                else
                    entry_length[slot] = '0;
            end
            default:
            begin
                if (slot >= used_slots || entry_length[slot] == '0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else
                begin
                    r.record_offset = entry_offset[slot];
                    r.length_out    = entry_length[slot];
                end
            end
        endcase
        if (page_free_end > directory_end(used_slots))
            r.free_bytes = LEN_W'(page_free_end - directory_end(used_slots));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: mismatch on %s: got %0d, wanted %0d", $time, what, got, want);
        fail_tally++;
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            used_slots    = 0;
            page_free_end = PAGE_BYTES;
            awaited_results.delete();
            outstanding   = 0;
        end
        else
        begin
            // compare first: a result leaving now belongs to an older request
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding, status", status, '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", status, want.status);
                    check_field("slot_index", slot_index, want.slot_index);
                    check_field("record_offset", record_offset, want.record_offset);
                    check_field("length_out", length_out, want.length_out);
                    check_field("free_bytes", free_bytes, want.free_bytes);
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_page_request(req_t'(req_type),
                    int'(record_length), int'(slot_number)));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_slotted_page_directory.sv =====
`timescale 1ns / 100ps
// Testbench top for the slotted page directory: clock, reset, request and
// result drivers, and the verdict. Depends on spd_pkg, the block and spd_checker.
module tb_slotted_page_directory
    import spd_pkg::*;
;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic [REQ_W-1:0]    req_type      = REQ_INIT;
    logic [LEN_W-1:0]    record_length = '0;
    logic [SLOT_W-1:0]   slot_number   = '0;
    logic                out_ready     = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [LEN_W-1:0]    record_offset;
    logic [LEN_W-1:0]    length_out;
    logic [LEN_W-1:0]    free_bytes;
    int                  mismatches;
    int                  pending;

    int                  requests_sent = 0;
    int                  slots_hint    = 0;
    bit                  steady_sender = 1'b0;

    slotted_page_directory DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .record_length (record_length),
        .slot_number   (slot_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot_index    (slot_index),
        .record_offset (record_offset),
        .length_out    (length_out),
        .free_bytes    (free_bytes)
    );

    spd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .record_length (record_length),
        .slot_number   (slot_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot_index    (slot_index),
        .record_offset (record_offset),
        .length_out    (length_out),
        .free_bytes    (free_bytes),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 65)
            return $urandom_range(1, 64);
        if (r < 85)
            return $urandom_range(65, 512);
        if (r < 97)
            return $urandom_range(513, 4095);
        return 4096;
    endfunction

    // aim mostly at slots that may exist, sometimes just past the end or anywhere
    function automatic int pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, slots_hint);
        if (r < 80)
            return (slots_hint + $urandom_range(0, 2)) % 1024;
        return $urandom_range(0, 1023);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue(req_t req, int len, int slot);
        int gap;
        gap = steady_sender ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        record_length <= LEN_W'(len);
        slot_number   <= SLOT_W'(slot);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
        if (req == REQ_INIT)
            slots_hint = 0;
        else if (req == REQ_INSERT && slots_hint < 1023)
            slots_hint++;
    endtask

    task automatic random_request(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            issue(REQ_INIT, $urandom_range(0, 4096), $urandom_range(0, 1023));
        else if (r < 3 + insert_pct)
            issue(REQ_INSERT, pick_length(), $urandom_range(0, 1023));
        else if (r < 3 + insert_pct + (97 - insert_pct) * 2 / 3)
            issue(REQ_LOOKUP, $urandom_range(0, 4096), pick_slot());
        else
            issue(REQ_TOMBSTONE, $urandom_range(0, 4096), pick_slot());
    endtask

    // Result side: random stalls, two long hold-offs to back up the request path,
    // and one stretch that never stalls.
    initial
    begin
        int cycle_no;
        int stall_left;
        cycle_no   = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if ((cycle_no >= 600 && cycle_no < 700) || (cycle_no >= 2600 && cycle_no < 2700))
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!(cycle_no >= 1200 && cycle_no < 1600))
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        int ops;
        int guard;
        int len;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty page, dead slots, out-of-range slots, exact fits and misses
        issue(REQ_INSERT, 0, 0);
        issue(REQ_LOOKUP, 0, 0);
        issue(REQ_LOOKUP, 0, 1023);
        issue(REQ_TOMBSTONE, 0, 1023);
        issue(REQ_INSERT, 4096, 0);
        issue(REQ_INSERT, 100, 0);
        issue(REQ_LOOKUP, 0, 1);
        issue(REQ_TOMBSTONE, 0, 1);
        issue(REQ_LOOKUP, 0, 1);
        issue(REQ_TOMBSTONE, 0, 0);
        issue(REQ_INSERT, 3960, 0);
        issue(REQ_INSERT, 0, 0);
        issue(REQ_LOOKUP, 0, 2);
        issue(REQ_INIT, 4096, 1023);
        issue(REQ_LOOKUP, 0, 0);
        issue(REQ_INSERT, 4096, 0);
        issue(REQ_INSERT, 4072, 0);
        issue(REQ_INSERT, 4068, 0);
        issue(REQ_LOOKUP, 0, 0);
        issue(REQ_INIT, 0, 0);
        issue(REQ_INSERT, 1, 0);
        issue(REQ_TOMBSTONE, 0, 0);

        // fill the directory with tiny records until inserts run out of room
        issue(REQ_INIT, 0, 0);
        steady_sender = 1'b1;
        for (int i = 0; i < 1100; i++)
        begin
            if (i == 150)
                steady_sender = 1'b0;
            if ($urandom_range(0, 99) < 88)
            begin
                len = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 3);
                issue(REQ_INSERT, len, $urandom_range(0, 1023));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                issue(REQ_LOOKUP, $urandom_range(0, 4096), pick_slot());
            end
            else
            begin
                issue(REQ_TOMBSTONE, $urandom_range(0, 4096), pick_slot());
            end
        end

        // mixed workloads, most of them on a freshly emptied page
        while (requests_sent < 1700)
        begin
            if ($urandom_range(0, 99) < 85)
                issue(REQ_INIT, $urandom_range(0, 4096), $urandom_range(0, 1023));
            ops = $urandom_range(10, 120);
            for (int i = 0; i < ops; i++)
                random_request(47);
        end
        in_valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
